[design/cls_pkg.sv]
package cls_pkg;

    localparam int DEFAULT_CAPACITY = 64;

    localparam int OP_W     = 2;
    localparam int INDEX_W  = 6;
    localparam int WORD_W   = 32;
    localparam int FILL_W   = 7;
    localparam int STATUS_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND    = 2'd0,
        OP_OVERWRITE = 2'd1,
        OP_READ      = 2'd2,
        OP_REMOVE    = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE      = 2'd0,
        STAT_BAD_INDEX = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NULL      = 2'd3
    } status_t;

endpackage

[design/compacting_list_store.sv]
// Fixed-capacity list of 32-bit handles held in one single-port-write RAM with a
// fill count. After reset the block zeroes every RAM slot before in_ready rises.
// One operation is in flight at a time. Append, overwrite and any refused operation
// complete straight from ST_IDLE, and a read waits in ST_READ for the registered RAM
// read. A remove steps through ST_SHIFT, because the single RAM write port moves one
// later entry down per cycle; it then zeroes the vacated top slot and lowers the
// fill count.
module compacting_list_store #(
    parameter int CAPACITY = cls_pkg::DEFAULT_CAPACITY
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [cls_pkg::OP_W-1:0]      op,
    input  logic [cls_pkg::INDEX_W-1:0]   index,
    input  logic [cls_pkg::WORD_W-1:0]    value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [cls_pkg::WORD_W-1:0]    read_value,
    output logic [cls_pkg::FILL_W-1:0]    fill_count,
    output logic [cls_pkg::STATUS_W-1:0]  status
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > cls_pkg::INDEX_W) ? CW : cls_pkg::INDEX_W;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_READ  = 4'b0100,
        ST_SHIFT = 4'b1000
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [AW-1:0]   clr_reg, clr_next;
    logic [CW-1:0]   ptr_reg, ptr_next;
    logic [AW-1:0]   wptr_reg, wptr_next;
    logic            pend_reg, pend_next;
    logic            out_valid_reg, out_valid_next;
    logic [cls_pkg::WORD_W-1:0]   rd_reg;
    logic [cls_pkg::FILL_W-1:0]   fill_reg;
    logic [cls_pkg::STATUS_W-1:0] stat_reg;

    logic                          load;
    logic [cls_pkg::WORD_W-1:0]    ld_rd;
    logic [CW-1:0]                 ld_cnt;
    cls_pkg::status_t              ld_stat;

    logic                          mem_we;
    logic [AW-1:0]                 mem_waddr;
    logic [cls_pkg::WORD_W-1:0]    mem_wdata;
    logic                          mem_re;
    logic [AW-1:0]                 mem_raddr;
    logic [cls_pkg::WORD_W-1:0]    mem_rdata;

    logic                          accept;
    logic [XW-1:0]                 idx_x;
    logic [XW-1:0]                 cnt_x;
    logic                          idx_bad;
    logic [CW-1:0]                 cnt_dec;

    cls_slot_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;
    assign idx_x    = XW'(index);
    assign cnt_x    = XW'(cnt_reg);
    assign idx_bad  = idx_x >= XW'(CAPACITY);
    assign cnt_dec  = cnt_reg - CW'(1);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        clr_next   = clr_reg;
        ptr_next   = ptr_reg;
        wptr_next  = wptr_reg;
        pend_next  = pend_reg;
        load       = 1'b0;
        ld_rd      = '0;
        ld_cnt     = cnt_reg;
        ld_stat    = cls_pkg::STAT_DONE;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = '0;
        mem_re     = 1'b0;
        mem_raddr  = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                if (clr_reg == AW'(CAPACITY - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + AW'(1);
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        cls_pkg::OP_APPEND:
                        begin
                            load = 1'b1;
                            if (value == '0)
                            begin
                                ld_stat = cls_pkg::STAT_NULL;
                            end
                            else if (cnt_reg >= CW'(CAPACITY))
                            begin
                                ld_stat = cls_pkg::STAT_FULL;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = cnt_reg[AW-1:0];
                                mem_wdata = value;
                                cnt_next  = cnt_reg + CW'(1);
                                ld_cnt    = cnt_reg + CW'(1);
                            end
                        end
                        cls_pkg::OP_OVERWRITE:
                        begin
                            load = 1'b1;
                            if (idx_bad)
                            begin
                                ld_stat = cls_pkg::STAT_BAD_INDEX;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = idx_x[AW-1:0];
                                mem_wdata = value;
                            end
                        end
                        cls_pkg::OP_READ:
                        begin
                            if (idx_bad)
                            begin
                                load    = 1'b1;
                                ld_stat = cls_pkg::STAT_BAD_INDEX;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = idx_x[AW-1:0];
                                state_next = ST_READ;
                            end
                        end
                        default:
                        begin
                            if (idx_x >= cnt_x)
                            begin
                                load    = 1'b1;
                                ld_stat = cls_pkg::STAT_BAD_INDEX;
                            end
                            else
                            begin
                                ptr_next   = CW'(idx_x) + CW'(1);
                                pend_next  = 1'b0;
                                state_next = ST_SHIFT;
                            end
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                load       = 1'b1;
                ld_rd      = mem_rdata;
                state_next = ST_IDLE;
            end
            ST_SHIFT:
            begin
                // Reads run one slot ahead of writes, so a slot is always read
                // before the entry above it lands on it.
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = wptr_reg;
                    mem_wdata = mem_rdata;
                end
                if (ptr_reg < cnt_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = ptr_reg[AW-1:0];
                    wptr_next = ptr_reg[AW-1:0] - AW'(1);
                    ptr_next  = ptr_reg + CW'(1);
                    pend_next = 1'b1;
                end
                else if (pend_reg)
                begin
                    pend_next = 1'b0;
                end
                else
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = cnt_dec[AW-1:0];
                    cnt_next   = cnt_dec;
                    load       = 1'b1;
                    ld_cnt     = cnt_dec;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            clr_reg       <= '0;
            ptr_reg       <= '0;
            wptr_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            clr_reg       <= clr_next;
            ptr_reg       <= ptr_next;
            wptr_reg      <= wptr_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rd_reg   <= ld_rd;
            fill_reg <= cls_pkg::FILL_W'(ld_cnt);
            stat_reg <= ld_stat;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_value = rd_reg;
    assign fill_count = fill_reg;
    assign status     = stat_reg;

endmodule

[design/cls_slot_ram.sv]
module cls_slot_ram #(
    parameter int DEPTH = cls_pkg::DEFAULT_CAPACITY,
    parameter int AW    = $clog2(cls_pkg::DEFAULT_CAPACITY)
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [AW-1:0]             waddr,
    input  logic [cls_pkg::WORD_W-1:0] wdata,
    input  logic                      re,
    input  logic [AW-1:0]             raddr,
    output logic [cls_pkg::WORD_W-1:0] rdata
);

    logic [cls_pkg::WORD_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[tb/list_store_checker.sv]
`timescale 1ns / 100ps

module list_store_checker #(
    parameter int CAPACITY = cls_pkg::DEFAULT_CAPACITY
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [cls_pkg::OP_W-1:0]      op,
    input  logic [cls_pkg::INDEX_W-1:0]   index,
    input  logic [cls_pkg::WORD_W-1:0]    value,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [cls_pkg::WORD_W-1:0]    read_value,
    input  logic [cls_pkg::FILL_W-1:0]    fill_count,
    input  logic [cls_pkg::STATUS_W-1:0]  status,
    output int                            failures,
    output int                            pending
);

    typedef struct packed {
        logic [cls_pkg::WORD_W-1:0] read_value;
        logic [cls_pkg::FILL_W-1:0] fill_count;
        cls_pkg::status_t           status;
    } list_result_t;

    logic [cls_pkg::WORD_W-1:0] shadow_slots [CAPACITY];
    int unsigned                shadow_count;
    list_result_t               expected_results [$];

    task automatic report_mismatch(input string what, input logic [cls_pkg::WORD_W-1:0] got,
                                   input logic [cls_pkg::WORD_W-1:0] want);
        $display("list store mismatch, %s: got %0h, expected %0h", what, got, want);
        failures++;
    endtask

    // Applies one operation to the shadow list and returns the beat the block should emit.
    function automatic list_result_t apply_op(input cls_pkg::op_t code,
                                              input logic [cls_pkg::INDEX_W-1:0] idx,
                                              input logic [cls_pkg::WORD_W-1:0] word);
        list_result_t res;
        int unsigned  i;
        res.read_value = '0;
        res.status     = cls_pkg::STAT_DONE;
        case (code)
            cls_pkg::OP_APPEND:
            begin
                // A null handle is refused even when the list is full.
                if (word == '0)
                    res.status = cls_pkg::STAT_NULL;
                else if (shadow_count >= CAPACITY)
                    res.status = cls_pkg::STAT_FULL;
                else
                begin
                    shadow_slots[shadow_count] = word;
                    shadow_count++;
                end
            end
            cls_pkg::OP_OVERWRITE:
            begin
                if (idx >= CAPACITY)
                    res.status = cls_pkg::STAT_BAD_INDEX;
                else
                    shadow_slots[idx] = word;
            end
            cls_pkg::OP_READ:
            begin
                if (idx >= CAPACITY)
                    res.status = cls_pkg::STAT_BAD_INDEX;
                else
                    res.read_value = shadow_slots[idx];
            end
            default:
            begin
                if (idx >= shadow_count)
                    res.status = cls_pkg::STAT_BAD_INDEX;
                else
                begin
                    for (i = idx; i + 1 < shadow_count; i++)
                        shadow_slots[i] = shadow_slots[i + 1];
                    shadow_slots[shadow_count - 1] = '0;
                    shadow_count--;
                end
            end
        endcase
        res.fill_count = cls_pkg::FILL_W'(shadow_count);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        list_result_t want;
        if (!rst_n)
        begin
            for (int k = 0; k < CAPACITY; k++)
                shadow_slots[k] = '0;
            shadow_count = 0;
            expected_results.delete();
            failures = 0;
            pending <= 0;
        end
        else
        begin
            // A result always trails its request, so check before recording a new request.
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result beat with nothing expected", read_value, '0);
                else
                begin
                    want = expected_results.pop_front();
                    if (read_value !== want.read_value)
                        report_mismatch("read_value", read_value, want.read_value);
                    if (fill_count !== want.fill_count)
                        report_mismatch("fill_count", fill_count, want.fill_count);
                    if (status !== want.status)
                        report_mismatch("status", status, want.status);
                end
            end
            if (in_valid && in_ready)
                expected_results.push_back(apply_op(cls_pkg::op_t'(op), index, value));
            pending <= expected_results.size();
        end
    end

endmodule

[tb/compacting_list_store_test.sv]
`timescale 1ns / 100ps

module compacting_list_store_test;

    localparam int HOLD_CYCLES = 200;
    localparam int STALL_LIMIT = 5000;
    localparam int ITEM_TARGET = 1000;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_ready;
    logic [cls_pkg::OP_W-1:0]       op;
    logic [cls_pkg::INDEX_W-1:0]    index;
    logic [cls_pkg::WORD_W-1:0]     value;
    logic                           out_valid;
    logic                           out_ready;
    logic [cls_pkg::WORD_W-1:0]     read_value;
    logic [cls_pkg::FILL_W-1:0]     fill_count;
    logic [cls_pkg::STATUS_W-1:0]   status;

    int failures;
    int pending;
    int beats_sent;
    int idle_cycles;
    bit calm;
    bit hold_req;

    always #1 clk = ~clk;

    compacting_list_store i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .index      (index),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_value (read_value),
        .fill_count (fill_count),
        .status     (status)
    );

    list_store_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .index      (index),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_value (read_value),
        .fill_count (fill_count),
        .status     (status),
        .failures   (failures),
        .pending    (pending)
    );

    // Ends the run if no beat moves on either channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("compacting_list_store_test: errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                // Long hold-off so the block fills up and stalls its input.
                out_ready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++)
                    @(posedge clk);
                hold_req = 1'b0;
            end
            else
                out_ready <= calm || ($urandom_range(0, 99) >= 38);
        end
    end

    task automatic send_beat(input cls_pkg::op_t code, input logic [cls_pkg::INDEX_W-1:0] idx,
                             input logic [cls_pkg::WORD_W-1:0] word);
        while (!calm && $urandom_range(0, 99) < 38)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= code;
        index    <= idx;
        value    <= word;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        beats_sent++;
    endtask

    task automatic drain_wait();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Enough appends to reach a full list from any fill level, then some refused ones.
    task automatic fill_burst();
        repeat (70)
            send_beat(cls_pkg::OP_APPEND, cls_pkg::INDEX_W'($urandom()), $urandom() | 32'h1);
    endtask

    task automatic mixed_burst(input int count);
        int                         sel;
        logic [cls_pkg::WORD_W-1:0] word;
        repeat (count)
        begin
            sel = $urandom_range(0, 9);
            word = (sel == 0) ? '0 : (sel == 1) ? '1 : $urandom();
            send_beat(cls_pkg::op_t'($urandom_range(0, 3)),
                      cls_pkg::INDEX_W'($urandom_range(0, 63)), word);
        end
    endtask

    initial
    begin
        in_valid   <= 1'b0;
        op         <= cls_pkg::OP_APPEND;
        index      <= '0;
        value      <= '0;
        rst_n      <= 1'b0;
        calm       = 1'b0;
        hold_req   = 1'b0;
        beats_sent = 0;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;

        // Empty list: reads of untouched slots, a remove with nothing held, a null append.
        send_beat(cls_pkg::OP_READ, 6'd0, '0);
        send_beat(cls_pkg::OP_READ, 6'd63, '1);
        send_beat(cls_pkg::OP_REMOVE, 6'd0, '0);
        send_beat(cls_pkg::OP_APPEND, 6'd0, '0);
        send_beat(cls_pkg::OP_APPEND, 6'd63, '1);
        send_beat(cls_pkg::OP_APPEND, 6'd0, 32'h1);
        send_beat(cls_pkg::OP_APPEND, 6'd0, 32'h8000_0000);
        // Overwrite above the count and read it back, then overwrites, removes and an append into a vacated slot.
        send_beat(cls_pkg::OP_OVERWRITE, 6'd63, 32'hA5A5_A5A5);
        send_beat(cls_pkg::OP_READ, 6'd63, '0);
        send_beat(cls_pkg::OP_OVERWRITE, 6'd3, 32'h1234_5678);
        send_beat(cls_pkg::OP_OVERWRITE, 6'd1, '0);
        send_beat(cls_pkg::OP_READ, 6'd1, '0);
        send_beat(cls_pkg::OP_REMOVE, 6'd3, '0);
        send_beat(cls_pkg::OP_REMOVE, 6'd2, '0);
        send_beat(cls_pkg::OP_REMOVE, 6'd0, '0);
        send_beat(cls_pkg::OP_READ, 6'd0, '0);
        send_beat(cls_pkg::OP_READ, 6'd1, '0);
        send_beat(cls_pkg::OP_APPEND, 6'd0, 32'h5A5A_5A5A);
        send_beat(cls_pkg::OP_READ, 6'd1, '0);
        send_beat(cls_pkg::OP_READ, 6'd3, '0);
        drain_wait();

        hold_req = 1'b1;
        fill_burst();
        drain_wait();

        calm = 1'b1;
        mixed_burst(150);
        calm = 1'b0;

        while (beats_sent < ITEM_TARGET)
        begin
            case ($urandom_range(0, 9))
                0, 1: fill_burst();
                2, 3:
                    repeat (70)
                        send_beat(cls_pkg::OP_REMOVE,
                                  cls_pkg::INDEX_W'($urandom_range(0, 7)), $urandom());
                default: mixed_burst(30);
            endcase
            if ($urandom_range(0, 3) == 0)
                drain_wait();
        end

        drain_wait();
        repeat (70)
            @(posedge clk);
        if (failures == 0)
            $display("compacting_list_store_test: clean");
        else
            $display("compacting_list_store_test: errors");
        $finish;
    end

endmodule

[sim.f]
design/cls_pkg.sv
design/cls_slot_ram.sv
design/compacting_list_store.sv
tb/list_store_checker.sv
tb/compacting_list_store_test.sv
